@@ sv/srtf_schedule_simulator_macros.svh @@
// assertion macros shared by the srtf scheduler rtl
`ifndef SRTF_SCHEDULE_SIMULATOR_MACROS_SVH
`define SRTF_SCHEDULE_SIMULATOR_MACROS_SVH

// condition holds at every clock edge out of reset
`define SRTF_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("srtf assertion failed: invariant");

// consequent holds in the same cycle as the antecedent
`define SRTF_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("srtf assertion failed: same-cycle implication");

// consequent holds in the cycle after the antecedent
`define SRTF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("srtf assertion failed: next-cycle implication");

`endif

@@ sv/srtf_pkg.sv @@
// shared types and constants of the srtf schedule simulator
`timescale 1ns / 1ps

package srtf_pkg;

    localparam int MAX_PROCS_DEF = 16;
    localparam int CLK_W_DEF     = 21;
    localparam int TIME_W        = 21;
    localparam logic [16:0] NO_REMAINING = 17'h10000;

    typedef struct packed {
        logic [15:0] process_id;
        logic [15:0] arrival_time;
        logic [15:0] burst_time;
        logic        last_item;
    } in_item_t;

    typedef struct packed {
        logic [15:0]       result_id;
        logic [TIME_W-1:0] waiting_time;
        logic [TIME_W-1:0] turnaround_time;
        logic              last_result;
    } out_item_t;

    typedef struct packed {
        logic [15:0] process_id;
        logic [15:0] arrival_time;
        logic [15:0] burst_time;
        logic [15:0] remaining_time;
    } rec_t;

    localparam int REC_W = $bits(rec_t);

    typedef struct packed {
        logic take;
        logic next_upd;
    } scan_res_t;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_DECIDE,
        ST_DELTA,
        ST_CLOCK,
        ST_REM,
        ST_NEED,
        ST_WAIT,
        ST_ORD,
        ST_OCALC
    } state_t;

endpackage

@@ sv/srtf_schedule_simulator.sv @@
// top level of the srtf schedule simulator: sequencer, stores and result register
`timescale 1ns / 1ps
`include "srtf_schedule_simulator_macros.svh"

// usage
//   item channel (item_valid/item_ready/item): one process per transaction;
//   one item is taken per cycle while loading. items beyond MAX_PROCS are
//   dropped, but a dropped item's last_item bit still starts the simulation
//   item_ready is high only while the block loads; it drops for the whole
//   simulation and result phase that follows an item marked last_item
//   simulation is event driven: each scheduling decision passes the check
//   state, scans all n stored records through the single read port of the
//   record memory and, when a process is picked, steps through the decide,
//   delta, clock and then rem or need and wait states of the shared
//   add/subtract unit; at most about 3n decisions, whatever the burst lengths
//   result channel (result_valid/result_ready/result): one transaction per
//   loaded process, in load order, last_result set on the final one; each
//   result is a memory read (ord state), then an add (ocalc state)
//   a stalled receiver holds the result register; the sequencer waits on it
//   and the next set can be loaded while the final result is still pending
//   reset clears the load count and the sequencer; the record memory needs
//   no clearing since only records written in the current set are read
module srtf_schedule_simulator #(
    parameter int MAX_PROCS = srtf_pkg::MAX_PROCS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  srtf_pkg::in_item_t  item,
    output logic                result_valid,
    input  logic                result_ready,
    output srtf_pkg::out_item_t result
);

    import srtf_pkg::*;

    localparam int CNT_W = $clog2(MAX_PROCS + 1);
    localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CLK_W = 16 + CNT_W;
    localparam int AW    = CLK_W + 1;
    localparam int MEM_W = REC_W + CLK_W;

    // sequencer state
    state_t state_reg, state_next;

    // set bookkeeping
    logic [CNT_W-1:0] load_cnt_reg, load_cnt_next;
    logic [CNT_W-1:0] zero_cnt_reg, zero_cnt_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [CNT_W-1:0] done_cnt_reg, done_cnt_next;

    // simulated time and the running process
    logic [CLK_W-1:0] clock_reg, clock_next;
    logic [IDX_W-1:0] run_idx_reg, run_idx_next;
    logic             running_valid_reg, running_valid_next;
    logic [15:0]      run_rem_reg, run_rem_next;

    // scan results
    logic [16:0]      best_reg, best_next;
    logic [IDX_W-1:0] pick_reg, pick_next;
    logic             found_reg, found_next;
    logic [15:0]      next_arr_reg, next_arr_next;
    logic             next_valid_reg, next_valid_next;
    logic [CNT_W-1:0] scan_idx_reg, scan_idx_next;
    logic             eval_valid_reg, eval_valid_next;
    logic [IDX_W-1:0] eval_idx_reg, eval_idx_next;

    // step operands
    logic [15:0]      gap_reg, gap_next;
    logic [15:0]      delta_reg, delta_next;
    logic             finish_reg, finish_next;
    logic [16:0]      need_reg, need_next;

    // result side
    logic [CNT_W-1:0] out_idx_reg, out_idx_next;
    logic             result_valid_reg, result_valid_next;
    out_item_t        result_reg, result_next;

    // memory port
    logic             mem_wr_en;
    logic [IDX_W-1:0] mem_wr_addr;
    logic [MEM_W-1:0] mem_wr_data;
    logic             mem_rd_en;
    logic [IDX_W-1:0] mem_rd_addr;
    logic [MEM_W-1:0] mem_rd_data;
    rec_t             rd_rec;
    logic [CLK_W-1:0] rd_wait;
    rec_t             wr_rec;
    logic [CLK_W-1:0] wr_wait;

    // shared unit
    alu_op_t          alu_op;
    logic [AW-1:0]    alu_a;
    logic [AW-1:0]    alu_b;
    logic [AW-1:0]    alu_res;
    logic             alu_borrow;
    scan_res_t        scan_res;

    // helpers
    logic             store_w;
    logic             store_zero_w;
    logic             use_gap_w;
    logic [CNT_W-1:0] out_idx_inc_w;
    logic             last_acc_w;

    assign rd_rec      = rec_t'(mem_rd_data[MEM_W-1:CLK_W]);
    assign rd_wait     = mem_rd_data[CLK_W-1:0];
    assign mem_wr_data = {wr_rec, wr_wait};

    assign item_ready   = (state_reg == ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // a full store drops the item's payload
    assign store_w       = (load_cnt_reg < CNT_W'(MAX_PROCS));
    assign store_zero_w  = store_w && (item.burst_time == 16'd0);
    // a pending arrival cuts the run short only when strictly sooner
    assign use_gap_w     = next_valid_reg && alu_borrow;
    assign out_idx_inc_w = out_idx_reg + CNT_W'(1);
    // final item of a set taken this cycle
    assign last_acc_w    = item_valid && item_ready && item.last_item;

    srtf_ram #(
        .DEPTH  (MAX_PROCS),
        .DATA_W (MEM_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    srtf_alu #(
        .CLK_W (CLK_W)
    ) u_alu (
        .op         (alu_op),
        .a          (alu_a),
        .b          (alu_b),
        .res        (alu_res),
        .borrow     (alu_borrow),
        .entry_rem  (rd_rec.remaining_time),
        .entry_arr  (rd_rec.arrival_time),
        .sim_clock  (clock_reg),
        .best       (best_reg),
        .next_arr   (next_arr_reg),
        .next_valid (next_valid_reg),
        .scan       (scan_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            load_cnt_reg      <= '0;
            zero_cnt_reg      <= '0;
            n_reg             <= '0;
            done_cnt_reg      <= '0;
            clock_reg         <= '0;
            run_idx_reg       <= '0;
            running_valid_reg <= 1'b0;
            run_rem_reg       <= '0;
            best_reg          <= '0;
            pick_reg          <= '0;
            found_reg         <= 1'b0;
            next_arr_reg      <= '0;
            next_valid_reg    <= 1'b0;
            scan_idx_reg      <= '0;
            eval_valid_reg    <= 1'b0;
            eval_idx_reg      <= '0;
            gap_reg           <= '0;
            delta_reg         <= '0;
            finish_reg        <= 1'b0;
            need_reg          <= '0;
            out_idx_reg       <= '0;
            result_valid_reg  <= 1'b0;
            result_reg        <= '0;
        end
        else
        begin
            state_reg         <= state_next;
            load_cnt_reg      <= load_cnt_next;
            zero_cnt_reg      <= zero_cnt_next;
            n_reg             <= n_next;
            done_cnt_reg      <= done_cnt_next;
            clock_reg         <= clock_next;
            run_idx_reg       <= run_idx_next;
            running_valid_reg <= running_valid_next;
            run_rem_reg       <= run_rem_next;
            best_reg          <= best_next;
            pick_reg          <= pick_next;
            found_reg         <= found_next;
            next_arr_reg      <= next_arr_next;
            next_valid_reg    <= next_valid_next;
            scan_idx_reg      <= scan_idx_next;
            eval_valid_reg    <= eval_valid_next;
            eval_idx_reg      <= eval_idx_next;
            gap_reg           <= gap_next;
            delta_reg         <= delta_next;
            finish_reg        <= finish_next;
            need_reg          <= need_next;
            out_idx_reg       <= out_idx_next;
            result_valid_reg  <= result_valid_next;
            result_reg        <= result_next;
        end
    end

    always_comb
    begin
        state_next         = state_reg;
        load_cnt_next      = load_cnt_reg;
        zero_cnt_next      = zero_cnt_reg;
        n_next             = n_reg;
        done_cnt_next      = done_cnt_reg;
        clock_next         = clock_reg;
        run_idx_next       = run_idx_reg;
        running_valid_next = running_valid_reg;
        run_rem_next       = run_rem_reg;
        best_next          = best_reg;
        pick_next          = pick_reg;
        found_next         = found_reg;
        next_arr_next      = next_arr_reg;
        next_valid_next    = next_valid_reg;
        scan_idx_next      = scan_idx_reg;
        eval_valid_next    = eval_valid_reg;
        eval_idx_next      = eval_idx_reg;
        gap_next           = gap_reg;
        delta_next         = delta_reg;
        finish_next        = finish_reg;
        need_next          = need_reg;
        out_idx_next       = out_idx_reg;
        result_next        = result_reg;

        mem_wr_en   = 1'b0;
        mem_wr_addr = pick_reg;
        wr_rec      = rd_rec;
        wr_wait     = rd_wait;
        mem_rd_en   = 1'b0;
        mem_rd_addr = pick_reg;

        alu_op = ALU_ADD;
        alu_a  = '0;
        alu_b  = '0;

        // result register empties when taken
        result_valid_next = result_valid_reg && !result_ready;

        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    if (store_w)
                    begin
                        // remaining starts at burst, waiting at zero
                        mem_wr_en             = 1'b1;
                        mem_wr_addr           = load_cnt_reg[IDX_W-1:0];
                        wr_rec.process_id     = item.process_id;
                        wr_rec.arrival_time   = item.arrival_time;
                        wr_rec.burst_time     = item.burst_time;
                        wr_rec.remaining_time = item.burst_time;
                        wr_wait               = '0;
                    end
                    load_cnt_next = load_cnt_reg + CNT_W'(store_w);
                    zero_cnt_next = zero_cnt_reg + CNT_W'(store_zero_w);
                    if (item.last_item)
                    begin
                        n_next             = load_cnt_reg + CNT_W'(store_w);
                        done_cnt_next      = zero_cnt_reg + CNT_W'(store_zero_w);
                        load_cnt_next      = '0;
                        zero_cnt_next      = '0;
                        clock_next         = '0;
                        run_idx_next       = '0;
                        running_valid_next = 1'b0;
                        state_next         = ST_CHECK;
                    end
                end
            end

            ST_CHECK:
            begin
                if (done_cnt_reg == n_reg)
                begin
                    out_idx_next = '0;
                    state_next   = ST_ORD;
                end
                else
                begin
                    // incumbent keeps the processor unless strictly beaten
                    best_next       = running_valid_reg ? {1'b0, run_rem_reg} : NO_REMAINING;
                    pick_next       = run_idx_reg;
                    found_next      = running_valid_reg;
                    next_valid_next = 1'b0;
                    scan_idx_next   = '0;
                    eval_valid_next = 1'b0;
                    state_next      = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                if (scan_idx_reg < n_reg)
                begin
                    mem_rd_en       = 1'b1;
                    mem_rd_addr     = scan_idx_reg[IDX_W-1:0];
                    scan_idx_next   = scan_idx_reg + CNT_W'(1);
                    eval_valid_next = 1'b1;
                    eval_idx_next   = scan_idx_reg[IDX_W-1:0];
                end
                else
                begin
                    eval_valid_next = 1'b0;
                    if (!eval_valid_reg)
                    begin
                        state_next = ST_DECIDE;
                    end
                end
                if (eval_valid_reg)
                begin
                    if (scan_res.take)
                    begin
                        best_next  = {1'b0, rd_rec.remaining_time};
                        pick_next  = eval_idx_reg;
                        found_next = 1'b1;
                    end
                    if (scan_res.next_upd)
                    begin
                        next_arr_next   = rd_rec.arrival_time;
                        next_valid_next = 1'b1;
                    end
                end
            end

            ST_DECIDE:
            begin
                if (!found_reg)
                begin
                    // idle: jump to the next arrival
                    clock_next = CLK_W'(next_arr_reg);
                    state_next = ST_CHECK;
                end
                else
                begin
                    alu_op      = ALU_SUB;
                    alu_a       = AW'(next_arr_reg);
                    alu_b       = AW'(clock_reg);
                    gap_next    = alu_res[15:0];
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = pick_reg;
                    state_next  = ST_DELTA;
                end
            end

            ST_DELTA:
            begin
                alu_op      = ALU_SUB;
                alu_a       = AW'(gap_reg);
                alu_b       = AW'(best_reg[15:0]);
                delta_next  = use_gap_w ? gap_reg : best_reg[15:0];
                finish_next = !use_gap_w;
                state_next  = ST_CLOCK;
            end

            ST_CLOCK:
            begin
                alu_op       = ALU_ADD;
                alu_a        = AW'(clock_reg);
                alu_b        = AW'(delta_reg);
                clock_next   = alu_res[CLK_W-1:0];
                run_idx_next = pick_reg;
                state_next   = finish_reg ? ST_NEED : ST_REM;
            end

            ST_REM:
            begin
                alu_op                = ALU_SUB;
                alu_a                 = AW'(best_reg[15:0]);
                alu_b                 = AW'(delta_reg);
                mem_wr_en             = 1'b1;
                mem_wr_addr           = pick_reg;
                wr_rec.remaining_time = alu_res[15:0];
                run_rem_next          = alu_res[15:0];
                running_valid_next    = 1'b1;
                state_next            = ST_CHECK;
            end

            ST_NEED:
            begin
                alu_op     = ALU_ADD;
                alu_a      = AW'(rd_rec.burst_time);
                alu_b      = AW'(rd_rec.arrival_time);
                need_next  = alu_res[16:0];
                state_next = ST_WAIT;
            end

            ST_WAIT:
            begin
                // waiting time clamps at zero
                alu_op                = ALU_SUB;
                alu_a                 = AW'(clock_reg);
                alu_b                 = AW'(need_reg);
                mem_wr_en             = 1'b1;
                mem_wr_addr           = pick_reg;
                wr_rec.remaining_time = '0;
                wr_wait               = alu_borrow ? '0 : alu_res[CLK_W-1:0];
                done_cnt_next         = done_cnt_reg + CNT_W'(1);
                running_valid_next    = 1'b0;
                state_next            = ST_CHECK;
            end

            ST_ORD:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = out_idx_reg[IDX_W-1:0];
                state_next  = ST_OCALC;
            end

            ST_OCALC:
            begin
                alu_op = ALU_ADD;
                alu_a  = AW'(rd_rec.burst_time);
                alu_b  = AW'(rd_wait);
                if (!result_valid_reg || result_ready)
                begin
                    result_next.result_id    = rd_rec.process_id;
                    result_next.waiting_time = TIME_W'(rd_wait);
                    // zero burst reports zero turnaround
                    result_next.turnaround_time =
                        (rd_rec.burst_time == 16'd0) ? '0 : TIME_W'(alu_res);
                    result_next.last_result  = (out_idx_inc_w == n_reg);
                    result_valid_next        = 1'b1;
                    out_idx_next             = out_idx_inc_w;
                    state_next               = (out_idx_inc_w == n_reg) ? ST_IDLE : ST_ORD;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // finished count never passes the set size
    `SRTF_ASSERT_ALWAYS(a_done_le_n, done_cnt_reg <= n_reg)
    // a running process always has service left
    `SRTF_ASSERT_SAME(a_run_rem_nonzero, running_valid_reg, run_rem_reg != 16'd0)
    // the final item starts the simulation at once
    `SRTF_ASSERT_NEXT(a_last_starts_sim, last_acc_w, state_reg == ST_CHECK)
    // results are only produced by the result step
    `SRTF_ASSERT_SAME(a_result_from_calc, $rose(result_valid_reg), $past(state_reg) == ST_OCALC)

endmodule

@@ sv/srtf_ram.sv @@
// process record memory, one write port and one registered read port
`timescale 1ns / 1ps

module srtf_ram #(
    parameter int DEPTH  = srtf_pkg::MAX_PROCS_DEF,
    parameter int DATA_W = srtf_pkg::REC_W + srtf_pkg::CLK_W_DEF,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ sv/srtf_alu.sv @@
// shared add/subtract unit and per-entry scan comparator
`timescale 1ns / 1ps

module srtf_alu #(
    parameter int CLK_W = srtf_pkg::CLK_W_DEF,
    localparam int AW = CLK_W + 1
) (
    input  srtf_pkg::alu_op_t   op,
    input  logic [AW-1:0]       a,
    input  logic [AW-1:0]       b,
    output logic [AW-1:0]       res,
    output logic                borrow,
    input  logic [15:0]         entry_rem,
    input  logic [15:0]         entry_arr,
    input  logic [CLK_W-1:0]    sim_clock,
    input  logic [16:0]         best,
    input  logic [15:0]         next_arr,
    input  logic                next_valid,
    output srtf_pkg::scan_res_t scan
);

    import srtf_pkg::*;

    logic [AW:0] sum_w;
    logic        arrived_w;
    logic        live_w;

    always_comb
    begin
        case (op)
            ALU_ADD: sum_w = {1'b0, a} + {1'b0, b};
            ALU_SUB: sum_w = {1'b0, a} - {1'b0, b};
            default: sum_w = '0;
        endcase
    end

    assign res    = sum_w[AW-1:0];
    assign borrow = (op == ALU_SUB) && sum_w[AW];

    // entry compare: arrived challengers vs best, pending arrivals vs earliest
    assign arrived_w = (CLK_W'(entry_arr) <= sim_clock);
    assign live_w    = (entry_rem != 16'd0);

    assign scan.take     = live_w && arrived_w && ({1'b0, entry_rem} < best);
    assign scan.next_upd = live_w && !arrived_w && (!next_valid || (entry_arr < next_arr));

endmodule
